// ----- rtl/tdm_pkg.sv -----
`default_nettype none

package tdm_pkg;

   // screen geometry and edge shaping
   localparam int SCREEN_WIDTH  = 800;
   localparam int SCREEN_HEIGHT = 480;
   localparam int EDGE_MARGIN   = 20;
   localparam int NUDGE_X       = 0;
   localparam int NUDGE_Y       = 0;
   localparam int ADC_BITS      = 12;

   // field widths
   localparam int ADC_W      = 12;
   localparam int SX_W       = 10;
   localparam int SY_W       = 9;
   localparam int TGT_W      = 16;
   localparam int PT_W       = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);

   // divider shapes: edge lanes and final lane
   localparam int EN_W = 2 * ADC_W;     // edge dividend magnitude
   localparam int FN_W = 2 * TGT_W;     // final dividend magnitude
   localparam int DV_W = TGT_W;         // remainder / divisor width of a step
   localparam int RES_W = FN_W + 3;     // signed axis result

   // register stages inside one axis unit
   localparam int AXIS_LAT = EN_W + FN_W + 4;

   // nudge arithmetic
   localparam int NV_W  = 32;
   localparam int NUD_W = 30;
   localparam int NSAT  = 1 << 20;
   localparam logic [NUD_W:0] RECIP = (NUD_W+1)'((64'd1 << NUD_W) / EDGE_MARGIN);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ADC_POINT1   = 3'd0,
      REG_ADC_POINT2   = 3'd1,
      REG_ADC_POINT3   = 3'd2,
      REG_ADC_POINT4   = 3'd3,
      REG_LCD_TARGET_X = 3'd4,
      REG_LCD_TARGET_Y = 3'd5,
      REG_XY_SWAP      = 3'd6,
      REG_CAL_VALID    = 3'd7
   } csr_idx_type;

   // corner set seen by one axis unit
   typedef struct packed {
      logic [ADC_W-1:0] k1;
      logic [ADC_W-1:0] k2;
      logic [ADC_W-1:0] a1;
      logic [ADC_W-1:0] a3;
      logic [ADC_W-1:0] b4;
      logic [ADC_W-1:0] b2;
      logic [TGT_W-1:0] t1;
      logic [TGT_W-1:0] t2;
   } axis_cfg_type;

   // one restoring step: {new remainder, quotient bit}
   function automatic logic [DV_W:0] div_step(input logic [DV_W-1:0] rem,
                                              input logic [DV_W-1:0] dvs,
                                              input logic b);
      logic [DV_W:0] sh;
      logic [DV_W:0] df;
      sh = {rem, b};
      df = sh - {1'b0, dvs};
      if (sh >= {1'b0, dvs}) begin
         return {df[DV_W-1:0], 1'b1};
      end
      return {sh[DV_W-1:0], 1'b0};
   endfunction

   // v / EDGE_MARGIN by reciprocal with one correction
   function automatic logic [NUD_W-1:0] nudge_div(input logic [NUD_W-1:0] v);
      logic [2*NUD_W:0] pr;
      logic [NUD_W-1:0] q0;
      logic [NUD_W-1:0] r;
      pr = (2*NUD_W+1)'(v) * (2*NUD_W+1)'(RECIP);
      q0 = NUD_W'(pr >> NUD_W);
      r  = v - NUD_W'(q0 * NUD_W'(EDGE_MARGIN));
      if (r >= NUD_W'(EDGE_MARGIN)) begin
         q0 = q0 + NUD_W'(1);
      end
      return q0;
   endfunction

   // limit a value to a window that keeps the nudge result after clamping
   function automatic logic signed [NV_W-1:0] sat_nv(input logic signed [RES_W-1:0] v);
      logic signed [RES_W-1:0] lo;
      logic signed [RES_W-1:0] hi;
      lo = -RES_W'(NSAT);
      hi = RES_W'(SCREEN_WIDTH + NSAT);
      if (v < lo) begin
         return NV_W'(lo);
      end
      if (v > hi) begin
         return NV_W'(hi);
      end
      return NV_W'(v);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tdm_req_if.sv -----
`default_nettype none

interface tdm_req_if;
   import tdm_pkg::*;

   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] raw_x;
   logic [ADC_W-1:0] raw_y;

   modport source (output valid, output raw_x, output raw_y, input ready);
   modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/tdm_rsp_if.sv -----
`default_nettype none

interface tdm_rsp_if;
   import tdm_pkg::*;

   logic            valid;
   logic            ready;
   logic [SX_W-1:0] screen_x;
   logic [SY_W-1:0] screen_y;
   logic            mapped_ok;

   modport source (output valid, output screen_x, output screen_y, output mapped_ok,
                   input ready);
   modport sink   (input valid, input screen_x, input screen_y, input mapped_ok,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/tdm_axis.sv -----
`default_nettype none

module tdm_axis (
   input  logic                            clock,
   input  logic                            en,
   input  logic [tdm_pkg::ADC_W-1:0]       raw,
   input  logic [tdm_pkg::ADC_W-1:0]       along,
   input  tdm_pkg::axis_cfg_type           cfg,
   output logic signed [tdm_pkg::RES_W-1:0] res
);
   import tdm_pkg::*;

   // static edge divisor (corner spacing along the other axis)
   logic signed [ADC_W:0]  ek_d;
   logic [ADC_W-1:0]       ek_mag;
   logic                   ek_zero;
   logic signed [ADC_W:0]  dl;
   logic [ADC_W-1:0]       e_base [2];
   logic [ADC_W-1:0]       e_top [2];

   assign ek_d    = $signed({1'b0, cfg.k2}) - $signed({1'b0, cfg.k1});
   assign ek_mag  = ek_d[ADC_W] ? ADC_W'(-ek_d) : ADC_W'(ek_d);
   assign ek_zero = (ek_d == '0);
   assign dl      = $signed({1'b0, along}) - $signed({1'b0, cfg.k1});
   assign e_base[0] = cfg.a1;
   assign e_top[0]  = cfg.a3;
   assign e_base[1] = cfg.b4;
   assign e_top[1]  = cfg.b2;

   // edge divider pipeline, one quotient bit per stage
   logic [DV_W-1:0]  e_rem_ff [2][EN_W+1];
   logic [EN_W-1:0]  e_nq_ff  [2][EN_W+1];
   logic             e_neg_ff [2][EN_W+1];
   logic [ADC_W-1:0] e_raw_ff [EN_W+1];
   logic [TGT_W-1:0] e_val_ff [2];
   logic [TGT_W-1:0] e_val_in [2];
   logic [ADC_W-1:0] e_rawq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e_raw_ff[0] <= raw;
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_eload
      logic signed [ADC_W:0]     da;
      logic signed [2*ADC_W+1:0] prod;
      logic [TGT_W-1:0]          q16;

      assign da   = $signed({1'b0, e_top[j]}) - $signed({1'b0, e_base[j]});
      assign prod = da * dl;
      assign q16  = e_nq_ff[j][EN_W][TGT_W-1:0];

      // edge value kept modulo 2^16
      always_comb begin
         if (ek_zero) begin
            e_val_in[j] = TGT_W'(e_base[j]);
         end else if (e_neg_ff[j][EN_W]) begin
            e_val_in[j] = TGT_W'(e_base[j]) - q16;
         end else begin
            e_val_in[j] = TGT_W'(e_base[j]) + q16;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            e_rem_ff[j][0] <= '0;
            e_nq_ff[j][0]  <= prod[2*ADC_W+1] ? EN_W'(-prod) : EN_W'(prod);
            e_neg_ff[j][0] <= prod[2*ADC_W+1] ^ ek_d[ADC_W];
            e_val_ff[j]    <= e_val_in[j];
         end
      end
   end

   for (genvar i = 1; i <= EN_W; i++) begin : g_estep
      for (genvar j = 0; j < 2; j++) begin : g_lane
         logic [DV_W:0] st;
         assign st = div_step(e_rem_ff[j][i-1], DV_W'(ek_mag), e_nq_ff[j][i-1][EN_W-1]);
         always_ff @(posedge clock) begin
            if (en) begin
               e_rem_ff[j][i] <= st[DV_W:1];
               e_nq_ff[j][i]  <= {e_nq_ff[j][i-1][EN_W-2:0], st[0]};
               e_neg_ff[j][i] <= e_neg_ff[j][i-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            e_raw_ff[i] <= e_raw_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_rawq_ff <= e_raw_ff[EN_W];
      end
   end

   // final interpolation setup: targets over the edge span
   logic signed [TGT_W:0]     dt;
   logic signed [TGT_W:0]     dr;
   logic signed [TGT_W:0]     dn;
   logic signed [2*TGT_W+1:0] fprod;

   assign dt    = $signed({1'b0, cfg.t2}) - $signed({1'b0, cfg.t1});
   assign dr    = $signed({(TGT_W+1-ADC_W)'(0), e_rawq_ff}) - $signed({1'b0, e_val_ff[0]});
   assign dn    = $signed({1'b0, e_val_ff[1]}) - $signed({1'b0, e_val_ff[0]});
   assign fprod = dt * dr;

   logic [DV_W-1:0] f_rem_ff [FN_W+1];
   logic [FN_W-1:0] f_nq_ff  [FN_W+1];
   logic [DV_W-1:0] f_den_ff [FN_W+1];
   logic            f_neg_ff [FN_W+1];
   logic            f_rz_ff  [FN_W+1];
   logic            f_dz_ff  [FN_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         f_rem_ff[0] <= '0;
         f_nq_ff[0]  <= fprod[2*TGT_W+1] ? FN_W'(-fprod) : FN_W'(fprod);
         f_den_ff[0] <= dn[TGT_W] ? DV_W'(-dn) : DV_W'(dn);
         f_neg_ff[0] <= fprod[2*TGT_W+1] ^ dn[TGT_W];
         f_rz_ff[0]  <= (e_rawq_ff == '0);
         f_dz_ff[0]  <= (dn == '0);
      end
   end

   for (genvar i = 1; i <= FN_W; i++) begin : g_fstep
      logic [DV_W:0] st;
      assign st = div_step(f_rem_ff[i-1], f_den_ff[i-1], f_nq_ff[i-1][FN_W-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            f_rem_ff[i] <= st[DV_W:1];
            f_nq_ff[i]  <= {f_nq_ff[i-1][FN_W-2:0], st[0]};
            f_den_ff[i] <= f_den_ff[i-1];
            f_neg_ff[i] <= f_neg_ff[i-1];
            f_rz_ff[i]  <= f_rz_ff[i-1];
            f_dz_ff[i]  <= f_dz_ff[i-1];
         end
      end
   end

   // apply sign and base target
   logic signed [RES_W-1:0] qs;
   logic signed [RES_W-1:0] res_in;
   logic signed [RES_W-1:0] res_ff;

   assign qs = $signed({(RES_W-FN_W)'(0), f_nq_ff[FN_W]});

   always_comb begin
      if (f_rz_ff[FN_W]) begin
         res_in = '0;
      end else if (f_dz_ff[FN_W]) begin
         res_in = RES_W'(cfg.t1);
      end else if (f_neg_ff[FN_W]) begin
         res_in = $signed(RES_W'(cfg.t1)) - qs;
      end else begin
         res_in = $signed(RES_W'(cfg.t1)) + qs;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ----- rtl/touch_adc_to_screen_map.sv -----
`default_nettype none

// Touch ADC to screen mapper. Takes one raw (raw_x, raw_y) word per cycle and
// returns one (screen_x, screen_y, mapped_ok) word per input, in order; stalls
// on the result side freeze the whole pipe. Each axis has two restoring
// dividers in series, one quotient bit per stage: 24 stages for the corner-edge
// interpolation and 32 for the target interpolation, plus setup, nudge and
// clamp stages. The user must write the calibration registers through the csr
// port only while no word is in flight; the block does not enforce it.
// mapped_ok follows cal_valid; with cal_valid low the coordinates are zero.
module touch_adc_to_screen_map (
   input  logic                              clock,
   input  logic                              reset,
   tdm_req_if.sink                           req,
   tdm_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [tdm_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [tdm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tdm_pkg::*;

   localparam int PIPE_N = AXIS_LAT + 2;

   // configuration registers
   logic [PT_W-1:0]       pt1_ff, pt2_ff, pt3_ff, pt4_ff;
   logic [CSR_DATA_W-1:0] tgx_ff, tgy_ff;
   logic                  swap_ff, cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt1_ff  <= '0;
         pt2_ff  <= '0;
         pt3_ff  <= '0;
         pt4_ff  <= '0;
         tgx_ff  <= '0;
         tgy_ff  <= '0;
         swap_ff <= 1'b0;
         cal_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            REG_ADC_POINT1:   pt1_ff  <= csr_wdata[PT_W-1:0];
            REG_ADC_POINT2:   pt2_ff  <= csr_wdata[PT_W-1:0];
            REG_ADC_POINT3:   pt3_ff  <= csr_wdata[PT_W-1:0];
            REG_ADC_POINT4:   pt4_ff  <= csr_wdata[PT_W-1:0];
            REG_LCD_TARGET_X: tgx_ff  <= csr_wdata;
            REG_LCD_TARGET_Y: tgy_ff  <= csr_wdata;
            REG_XY_SWAP:      swap_ff <= csr_wdata[0];
            REG_CAL_VALID:    cal_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // corner coordinates
   logic [ADC_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   assign x1 = pt1_ff[ADC_W-1:0];
   assign y1 = pt1_ff[2*ADC_W-1:ADC_W];
   assign x2 = pt2_ff[ADC_W-1:0];
   assign y2 = pt2_ff[2*ADC_W-1:ADC_W];
   assign x3 = pt3_ff[ADC_W-1:0];
   assign y3 = pt3_ff[2*ADC_W-1:ADC_W];
   assign x4 = pt4_ff[ADC_W-1:0];
   assign y4 = pt4_ff[2*ADC_W-1:ADC_W];

   // route corners and raw axes per swap setting
   axis_cfg_type     cfg_x, cfg_y;
   logic [ADC_W-1:0] ax, ay;

   assign ax = req.raw_x & ADC_MASK;
   assign ay = req.raw_y & ADC_MASK;

   always_comb begin
      cfg_x.t1 = tgx_ff[TGT_W-1:0];
      cfg_x.t2 = tgx_ff[2*TGT_W-1:TGT_W];
      cfg_y.t1 = tgy_ff[TGT_W-1:0];
      cfg_y.t2 = tgy_ff[2*TGT_W-1:TGT_W];
      if (!swap_ff) begin
         cfg_x.k1 = y1; cfg_x.k2 = y2; cfg_x.a1 = x1; cfg_x.a3 = x3;
         cfg_x.b4 = x4; cfg_x.b2 = x2;
         cfg_y.k1 = x1; cfg_y.k2 = x2; cfg_y.a1 = y1; cfg_y.a3 = y4;
         cfg_y.b4 = y3; cfg_y.b2 = y2;
      end else begin
         cfg_x.k1 = x1; cfg_x.k2 = x2; cfg_x.a1 = y1; cfg_x.a3 = y3;
         cfg_x.b4 = y4; cfg_x.b2 = y2;
         cfg_y.k1 = y1; cfg_y.k2 = y2; cfg_y.a1 = x1; cfg_y.a3 = x4;
         cfg_y.b4 = x3; cfg_y.b2 = x2;
      end
   end

   // pipe advances whenever the output word is free or taken
   logic adv;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   logic v_ff [PIPE_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_N; k++) begin
            v_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req.valid;
         for (int k = 1; k < PIPE_N; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         out_vld_ff <= v_ff[PIPE_N-1];
      end
   end

   logic signed [RES_W-1:0] res_x, res_y;

   tdm_axis u_axis_x (
      .clock (clock),
      .en    (adv),
      .raw   (swap_ff ? ay : ax),
      .along (swap_ff ? ax : ay),
      .cfg   (cfg_x),
      .res   (res_x)
   );

   tdm_axis u_axis_y (
      .clock (clock),
      .en    (adv),
      .raw   (swap_ff ? ax : ay),
      .along (swap_ff ? ay : ax),
      .cfg   (cfg_y),
      .res   (res_y)
   );

   // low-edge nudge on both axes
   localparam logic signed [NV_W-1:0] MARG = NV_W'(EDGE_MARGIN);
   localparam logic signed [NV_W-1:0] WMAX = NV_W'(SCREEN_WIDTH - 1);
   localparam logic signed [NV_W-1:0] HMAX = NV_W'(SCREEN_HEIGHT - 1);

   logic signed [NV_W-1:0] sx0, sy0, p1_x_in, p1_y_in, p1_x_ff, p1_y_ff;

   assign sx0 = sat_nv(res_x);
   assign sy0 = sat_nv(res_y);

   always_comb begin
      p1_y_in = sy0;
      p1_x_in = sx0;
      if (NUDGE_Y > 0 && sy0 < MARG) begin
         p1_y_in = sy0 + $signed(NV_W'(nudge_div(NUD_W'(MARG - sy0) * NUD_W'(NUDGE_Y))));
      end
      if (NUDGE_X > 0 && sx0 < MARG) begin
         p1_x_in = sat_nv(RES_W'(sx0)
                   + RES_W'(nudge_div(NUD_W'(MARG - sx0) * NUD_W'(NUDGE_X))));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_x_ff <= p1_x_in;
         p1_y_ff <= p1_y_in;
      end
   end

   // high-edge nudge on x
   logic signed [NV_W-1:0] p2_x_in, p2_x_ff, p2_y_ff;

   always_comb begin
      p2_x_in = p1_x_ff;
      if (NUDGE_X > 0 && p1_x_ff > WMAX - MARG) begin
         p2_x_in = p1_x_ff - $signed(NV_W'(nudge_div(NUD_W'(p1_x_ff - (WMAX - MARG))
                                                      * NUD_W'(NUDGE_X))));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_x_ff <= p2_x_in;
         p2_y_ff <= p1_y_ff;
      end
   end

   // clamp to the screen and drive the output word
   logic [SX_W-1:0] sx_in, sx_ff;
   logic [SY_W-1:0] sy_in, sy_ff;
   logic            ok_ff;

   always_comb begin
      if (p2_x_ff < 0) begin
         sx_in = '0;
      end else if (p2_x_ff > WMAX) begin
         sx_in = WMAX[SX_W-1:0];
      end else begin
         sx_in = p2_x_ff[SX_W-1:0];
      end
      if (p2_y_ff < 0) begin
         sy_in = '0;
      end else if (p2_y_ff > HMAX) begin
         sy_in = HMAX[SY_W-1:0];
      end else begin
         sy_in = p2_y_ff[SY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff <= cal_ff ? sx_in : '0;
         sy_ff <= cal_ff ? sy_in : '0;
         ok_ff <= cal_ff;
      end
   end

   assign rsp.valid     = out_vld_ff;
   assign rsp.screen_x  = sx_ff;
   assign rsp.screen_y  = sy_ff;
   assign rsp.mapped_ok = ok_ff;

endmodule

`default_nettype wire

// ----- rtl/tdm_chk.sv -----
`default_nettype none

module tdm_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tdm_pkg::SX_W-1:0]    screen_x,
   input logic [tdm_pkg::SY_W-1:0]    screen_y,
   input logic                        mapped_ok
);
   import tdm_pkg::*;

   // results stay on the screen
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(screen_x) <= SCREEN_WIDTH - 1))
      else $error("screen_x beyond screen");

   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(screen_y) <= SCREEN_HEIGHT - 1))
      else $error("screen_y beyond screen");

   // an unmapped word carries zero coordinates
   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !mapped_ok) |-> (screen_x == '0 && screen_y == '0))
      else $error("unmapped word with nonzero coordinates");

   // input side is open while the output register is empty
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input held off with empty output");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(screen_x) && $stable(screen_y) && $stable(mapped_ok)))
      else $error("stalled result changed");

endmodule

bind touch_adc_to_screen_map tdm_chk u_tdm_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .screen_x  (rsp.screen_x),
   .screen_y  (rsp.screen_y),
   .mapped_ok (rsp.mapped_ok)
);

`default_nettype wire

// ----- tb/touch_adc_to_screen_map_test.sv -----
`default_nettype none

module touch_adc_to_screen_map_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tdm_pkg::*;

   localparam int DRAIN_CYCLES = AXIS_LAT + 30;
   localparam int STALL_LIMIT  = 5000;

   typedef struct {
      logic [SX_W-1:0] screen_x;
      logic [SY_W-1:0] screen_y;
      logic            mapped_ok;
   } screen_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tdm_req_if req ();
   tdm_rsp_if rsp ();

   touch_adc_to_screen_map dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // shadow calibration
   logic [PT_W-1:0]  cal_pt [4];
   logic [31:0]      cal_tgt_x, cal_tgt_y;
   logic             cal_swap, cal_ok;

   screen_word_type screen_q [$];
   int  mismatch_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  idle_cycles = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_stalls_on = 1'b1;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic longint lerp(longint x1, longint y1, longint x2, longint y2,
                                   longint x);
      if (x2 == x1) begin
         return y1;
      end
      return y1 + ((y2 - y1) * (x - x1)) / (x2 - x1);
   endfunction

   function automatic longint axis_map(longint raw, longint along, longint k1, longint k2,
                                       longint a1, longint a3, longint b4, longint b2,
                                       logic [31:0] tgt);
      longint e1, e2;
      e1 = lerp(k1, a1, k2, a3, along) & 64'hFFFF;
      e2 = lerp(k1, b4, k2, b2, along) & 64'hFFFF;
      if (raw == 0) begin
         return 0;
      end
      return lerp(e1, longint'(tgt[15:0]), e2, longint'(tgt[31:16]), raw);
   endfunction

   function automatic screen_word_type map_touch(logic [ADC_W-1:0] raw_x,
                                                 logic [ADC_W-1:0] raw_y);
      screen_word_type r;
      longint ax, ay, sx, sy, m, w, h;
      longint px [4];
      longint py [4];
      ax = longint'(raw_x & ADC_MASK);
      ay = longint'(raw_y & ADC_MASK);
      m = EDGE_MARGIN;
      w = SCREEN_WIDTH - 1;
      h = SCREEN_HEIGHT - 1;
      for (int i = 0; i < 4; i++) begin
         px[i] = longint'(cal_pt[i][11:0]);
         py[i] = longint'(cal_pt[i][23:12]);
      end
      if (!cal_ok) begin
         r.screen_x = '0;
         r.screen_y = '0;
         r.mapped_ok = 1'b0;
         return r;
      end
      if (!cal_swap) begin
         sx = axis_map(ax, ay, py[0], py[1], px[0], px[2], px[3], px[1], cal_tgt_x);
         sy = axis_map(ay, ax, px[0], px[1], py[0], py[3], py[2], py[1], cal_tgt_y);
      end else begin
         sx = axis_map(ay, ax, px[0], px[1], py[0], py[2], py[3], py[1], cal_tgt_x);
         sy = axis_map(ax, ay, py[0], py[1], px[0], px[3], px[2], px[1], cal_tgt_y);
      end
      // nudge values near the screen edges inward
      if (sy < m && NUDGE_Y > 0) begin
         sy += (m - sy) * NUDGE_Y / m;
      end
      if (sx < m && NUDGE_X > 0) begin
         sx += (m - sx) * NUDGE_X / m;
      end
      if (sx > w - m && NUDGE_X > 0) begin
         sx -= (sx - (w - m)) * NUDGE_X / m;
      end
      // clamp to the screen
      if (sx < 0) sx = 0; else if (sx > w) sx = w;
      if (sy < 0) sy = 0; else if (sy > h) sy = h;
      r.screen_x = SX_W'(sx);
      r.screen_y = SY_W'(sy);
      r.mapped_ok = 1'b1;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("MISMATCH word %0d: %s got %0d expected %0d", words_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      screen_word_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (screen_q.size() == 0) begin
            report_mismatch("unexpected word, queue depth", 1, 0);
         end else begin
            want = screen_q.pop_front();
            if (rsp.screen_x !== want.screen_x)
               report_mismatch("screen_x", rsp.screen_x, want.screen_x);
            if (rsp.screen_y !== want.screen_y)
               report_mismatch("screen_y", rsp.screen_y, want.screen_y);
            if (rsp.mapped_ok !== want.mapped_ok)
               report_mismatch("mapped_ok", rsp.mapped_ok, want.mapped_ok);
         end
         words_checked++;
      end
   end

   // predict on every accepted input word
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         screen_q.push_back(map_touch(req.raw_x, req.raw_y));
      end
   end

   // watchdog on cycles without progress
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without progress", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      int n;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         n = rsp_stalls_on ? $urandom_range(0, 3) : 0;
         rsp.ready = (n == 0);
         repeat (n) @(negedge clock);
         rsp.ready = 1'b1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_touch(logic [ADC_W-1:0] rx, logic [ADC_W-1:0] ry);
      int n;
      n = req_gaps_on ? $urandom_range(0, 3) : 0;
      repeat (n) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.raw_x = rx;
      req.raw_y = ry;
      do @(posedge clock); while (!req.ready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req.valid = 1'b0;
      while (screen_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      csr_we = 1'b1;
      csr_idx = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_ADC_POINT1:   cal_pt[0] = data[PT_W-1:0];
         REG_ADC_POINT2:   cal_pt[1] = data[PT_W-1:0];
         REG_ADC_POINT3:   cal_pt[2] = data[PT_W-1:0];
         REG_ADC_POINT4:   cal_pt[3] = data[PT_W-1:0];
         REG_LCD_TARGET_X: cal_tgt_x = data;
         REG_LCD_TARGET_Y: cal_tgt_y = data;
         REG_XY_SWAP:      cal_swap = data[0];
         REG_CAL_VALID:    cal_ok = data[0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] corner(int cx, int cy);
      return {8'h00, 12'(cy), 12'(cx)};
   endfunction

   // load a full calibration set once the pipe has drained
   task automatic load_cal(logic [31:0] p1, logic [31:0] p2, logic [31:0] p3,
                           logic [31:0] p4, logic [31:0] tx, logic [31:0] ty,
                           logic swap, logic ok);
      wait_idle();
      write_reg(REG_ADC_POINT1, p1);
      write_reg(REG_ADC_POINT2, p2);
      write_reg(REG_ADC_POINT3, p3);
      write_reg(REG_ADC_POINT4, p4);
      write_reg(REG_LCD_TARGET_X, tx);
      write_reg(REG_LCD_TARGET_Y, ty);
      write_reg(REG_XY_SWAP, {31'd0, swap});
      write_reg(REG_CAL_VALID, {31'd0, ok});
   endtask

   task automatic load_typical_cal(logic swap, int jitter);
      load_cal(corner(300 + $urandom_range(0, jitter), 300 + $urandom_range(0, jitter)),
               corner(3800 - $urandom_range(0, jitter), 3800 - $urandom_range(0, jitter)),
               corner(300 + $urandom_range(0, jitter), 3800 - $urandom_range(0, jitter)),
               corner(3800 - $urandom_range(0, jitter), 300 + $urandom_range(0, jitter)),
               {16'd779, 16'd20}, {16'd459, 16'd20}, swap, 1'b1);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_invalid_cal();
      load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0, 1'b0);
      send_touch(12'd0, 12'd0);
      send_touch(12'hFFF, 12'hFFF);
      send_touch(12'd2048, 12'd1000);
   endtask

   task automatic test_corner_readings();
      logic [ADC_W-1:0] edge_vals [5];
      edge_vals = '{12'd0, 12'd1, 12'd300, 12'd3800, 12'hFFF};
      for (int s = 0; s < 2; s++) begin
         load_typical_cal(logic'(s), 0);
         foreach (edge_vals[i]) send_touch(edge_vals[i], edge_vals[4 - i]);
         send_touch(12'd2050, 12'd2050);
         send_touch(12'd0, 12'd2050);
         send_touch(12'd2050, 12'd0);
      end
   endtask

   task automatic test_degenerate_cal();
      // equal corners make every division bound collapse
      load_cal(corner(1000, 1000), corner(1000, 1000), corner(1000, 1000),
               corner(1000, 1000), {16'd500, 16'd100}, {16'd300, 16'd50}, 1'b0, 1'b1);
      send_touch(12'd500, 12'd1500);
      send_touch(12'd1000, 12'd1000);
      // all-ones and all-zero register extremes
      load_cal(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
      send_touch(12'hFFF, 12'd1);
      send_touch(12'd7, 12'hFFF);
      load_cal(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
      send_touch(12'd1234, 12'd3210);
   endtask

   task automatic test_random_touches();
      int kind;
      logic [ADC_W-1:0] rx, ry;
      for (int phase = 0; phase < 12; phase++) begin
         kind = $urandom_range(0, 9);
         req_gaps_on = (phase % 4) != 1;
         rsp_stalls_on = (phase % 4) != 2;
         if (kind < 6) begin
            load_typical_cal(logic'($urandom_range(0, 1)), 400);
         end else if (kind < 9) begin
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     logic'($urandom_range(0, 1)), $urandom_range(0, 5) != 0);
         end else begin
            load_typical_cal(logic'($urandom_range(0, 1)), 0);
            write_reg(REG_CAL_VALID, 32'd0);
         end
         for (int i = 0; i < 128; i++) begin
            case ($urandom_range(0, 9))
               0: begin rx = 12'd0; ry = ADC_W'($urandom); end
               1: begin rx = ADC_W'($urandom); ry = 12'd0; end
               2: begin rx = ADC_W'($urandom); ry = ADC_W'($urandom); end
               3: begin rx = $urandom_range(0, 1) ? 12'hFFF : 12'd0;
                        ry = $urandom_range(0, 1) ? 12'hFFF : 12'd0; end
               default: begin rx = ADC_W'($urandom_range(200, 3900));
                              ry = ADC_W'($urandom_range(200, 3900)); end
            endcase
            send_touch(rx, ry);
         end
      end
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      req.valid = 1'b0;
      req.raw_x = '0;
      req.raw_y = '0;
      cal_pt = '{default: '0};
      cal_tgt_x = '0;
      cal_tgt_y = '0;
      cal_swap = 1'b0;
      cal_ok = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_invalid_cal();
      test_corner_readings();
      test_degenerate_cal();
      test_random_touches();

      // drain the pipe
      wait_idle();
      $display("Mapped %0d touch words over typical, random, degenerate and invalid",
               words_sent);
      $display("calibrations, both axis orders, with source gaps and sink stalls.");
      if (mismatch_count == 0 && screen_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d words still expected", mismatch_count,
                  screen_q.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
